// ----- sv/lbs_pkg.sv -----
// Package: shared types and constants for the skinning block.
`default_nettype none
package lbs_pkg;

  localparam int WordsPerJoint = 12;
  localparam int SlotFields    = 4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SKIN = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [0:0]         func;
    logic [7:0]         joint_sel;
    logic [3:0]         elem_sel;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [31:0]        bone_ids;
    logic [63:0]        bone_weights;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } res_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = S32_MAX;
    else if (x < -64'sd2147483648) r = S32_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/lbs_if.sv -----
// Interfaces: valid/ready request and result channels.
`default_nettype none
interface lbs_req_if import lbs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbs_res_if import lbs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/linear_blend_skinning_top.sv -----
// Top level: vertex skinning over a joint palette held in memory.
// Usage:
//   req channel carries load (func 0) and skin (func 1) requests.
//   A load writes one palette word and gives no result;
//   loads can be taken on every cycle while no skin request is in progress.
//   A skin request reads one joint per cycle from the palette memory,
//   up to four slots, stopping at the first zero weight; each read goes
//   through a registered memory, a product register and the accumulator.
//   After the issue phase a drain state lets the last reads pass the
//   product register and the accumulator before the result register is
//   written. A new skin request is taken only once the result of the
//   last one is in the output register.
//   The result sits in an output register; the next request is taken
//   while it waits, and work stalls only when a new result is ready
//   and the old one is not yet taken.
//   Reset clears the control state; palette words must be loaded before
//   they are referenced.
`default_nettype none
module linear_blend_skinning_top import lbs_pkg::*; #(
  parameter int NUM_JOINTS = 256,
  parameter int BONES_PER_VERTEX = 4
) (
  input wire logic clk,
  input wire logic rst,
  lbs_req_if.sink req,
  lbs_res_if.source res
);
  localparam int JW = $clog2(NUM_JOINTS);
  localparam int Slots = (BONES_PER_VERTEX < SlotFields) ? BONES_PER_VERTEX : SlotFields;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ISSUE = 4'b0010, S_DRAIN = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state;
  req_t cur;
  logic [2:0] slot;
  // Pipeline tags: valid/weight for memory stage and product stage.
  logic v1, v2;
  logic [15:0] w1, w2;
  logic signed [63:0] acc [6];
  logic [WordsPerJoint*32-1:0] rdata;
  logic signed [31:0] pt [3];
  logic signed [31:0] nt [3];
  logic [7:0] id;
  logic [15:0] w;
  logic stop, issue, accept, we;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign id = cur.bone_ids[slot[1:0]*8 +: 8];
  assign w = cur.bone_weights[slot[1:0]*16 +: 16];
  assign stop = (32'(slot) >= Slots) || (w == 16'd0);
  assign issue = (state == S_ISSUE) && !stop;
  assign we = accept && req.data.func == FUNC_LOAD && req.data.elem_sel < 4'd12
              && 32'(req.data.joint_sel) < NUM_JOINTS;

  lbs_palette #(.NUM_JOINTS(NUM_JOINTS)) u_pal (
    .clk, .we, .wjoint(JW'(req.data.joint_sel)), .welem(req.data.elem_sel),
    .wdata(req.data.matrix_value), .rjoint(JW'(id)), .rdata
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    lbs_row u_row (
      .clk, .row(rdata[r*128 +: 128]),
      .p0(cur.pos_x), .p1(cur.pos_y), .p2(cur.pos_z),
      .n0(cur.nrm_x), .n1(cur.nrm_y), .n2(cur.nrm_z),
      .pt(pt[r]), .nt(nt[r])
    );
  end

  // Sequence slots and accumulate weighted terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; v1 <= 1'b0; v2 <= 1'b0; res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      v1 <= issue && (32'(id) < NUM_JOINTS);
      w1 <= w;
      v2 <= v1; w2 <= w1;
      if (v2) begin
        for (int r = 0; r < 3; r++) begin
          acc[r]   <= acc[r]   + 64'(pt[r]) * $signed({1'b0, w2});
          acc[3+r] <= acc[3+r] + 64'(nt[r]) * $signed({1'b0, w2});
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.data.func == FUNC_SKIN) begin
            cur <= req.data; slot <= 3'd0; state <= S_ISSUE;
            for (int i = 0; i < 6; i++) acc[i] <= 64'sd0;
          end
        end
        S_ISSUE: begin
          if (stop) begin
            slot <= 3'd0; state <= S_DRAIN;
          end else slot <= slot + 3'd1;
        end
        S_DRAIN: begin
          if (slot == 3'd2) state <= S_DONE;
          else slot <= slot + 3'd1;
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.data.out_pos_x <= sat32((acc[0] + 64'sh4000) >>> 15);
            res.data.out_pos_y <= sat32((acc[1] + 64'sh4000) >>> 15);
            res.data.out_pos_z <= sat32((acc[2] + 64'sh4000) >>> 15);
            res.data.out_nrm_x <= sat32((acc[3] + 64'sh4000) >>> 15);
            res.data.out_nrm_y <= sat32((acc[4] + 64'sh4000) >>> 15);
            res.data.out_nrm_z <= sat32((acc[5] + 64'sh4000) >>> 15);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/lbs_palette.sv -----
// Palette memory: twelve word banks, one per matrix word, one joint read per cycle.
`default_nettype none
module lbs_palette import lbs_pkg::*; #(
  parameter int NUM_JOINTS = 256
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(NUM_JOINTS)-1:0] wjoint,
  input  wire logic [3:0] welem,
  input  wire logic [31:0] wdata,
  input  wire logic [$clog2(NUM_JOINTS)-1:0] rjoint,
  output logic [WordsPerJoint*32-1:0] rdata
);
  // One bank per matrix word; all banks read at the same joint address.
  for (genvar e = 0; e < WordsPerJoint; e++) begin : g_bank
    logic [31:0] mem [NUM_JOINTS];
    logic [31:0] q;

    // Write the addressed word, register the read data.
    always_ff @(posedge clk) begin
      if (we && welem == 4'(e)) mem[wjoint] <= wdata;
      q <= mem[rjoint];
    end

    assign rdata[e*32 +: 32] = q;
  end
endmodule
`default_nettype wire

// ----- sv/lbs_row.sv -----
// Row transform unit: one matrix row against position and normal, registered.
`default_nettype none
module lbs_row import lbs_pkg::*; (
  input  wire logic clk,
  input  wire logic [127:0] row,
  input  wire logic signed [31:0] p0, p1, p2, n0, n1, n2,
  output logic signed [31:0] pt,
  output logic signed [31:0] nt
);
  logic signed [63:0] mp [3];
  logic signed [63:0] mn [3];
  logic signed [31:0] m [4];
  logic signed [31:0] t3;
  logic signed [65:0] sp, sn;

  always_comb begin
    for (int c = 0; c < 4; c++) m[c] = row[c*32 +: 32];
  end

  // Register products before summing.
  always_ff @(posedge clk) begin
    mp[0] <= m[0] * p0; mp[1] <= m[1] * p1; mp[2] <= m[2] * p2;
    mn[0] <= m[0] * n0; mn[1] <= m[1] * n1; mn[2] <= m[2] * n2;
    t3 <= m[3];
  end

  // Round half up, add translation to the position only, saturate.
  always_comb begin
    sp = 66'(mp[0]) + 66'(mp[1]) + 66'(mp[2]) + 66'sh8000;
    sn = 66'(mn[0]) + 66'(mn[1]) + 66'(mn[2]) + 66'sh8000;
    pt = sat32(64'(sp >>> 16) + 64'(t3));
    nt = sat32(64'(sn >>> 16));
  end
endmodule
`default_nettype wire
